### sv/fsq_pkg.sv
// ----------------------------------------------------------------------------
// fsq_pkg
// Shared types, opcodes and helper functions for the four-square decrypter.
// ----------------------------------------------------------------------------
package fsq_pkg;

  localparam int unsigned SQUARE_SIZE = 25;
  localparam int unsigned IDX_W       = 5;

  localparam logic [IDX_W-1:0] SIDE     = 5'd5;
  localparam logic [IDX_W-1:0] LAST_IDX = 5'd24;
  localparam logic [7:0]       ASCII_A  = 8'h41;

  localparam logic [1:0] OP_LOAD_ONE = 2'd0;
  localparam logic [1:0] OP_LOAD_TWO = 2'd1;
  localparam logic [1:0] OP_TEXT     = 2'd2;

  typedef struct packed {
    logic [7:0] letter;
    logic       last;
    logic       err;
  } out_item_t;

  typedef struct packed {
    logic             found_a;
    logic             found_b;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
  } scan_result_t;

  function automatic logic [2:0] row_of(input logic [IDX_W-1:0] idx);
    logic [2:0] r;
    if (idx >= 5'd20)      r = 3'd4;
    else if (idx >= 5'd15) r = 3'd3;
    else if (idx >= 5'd10) r = 3'd2;
    else if (idx >= 5'd5)  r = 3'd1;
    else                   r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] col_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] c;
    base = IDX_W'(row_of(idx)) * SIDE;
    c    = idx - base;
    return c[2:0];
  endfunction

  // J-less alphabet: A..I, then K..Z
  function automatic logic [7:0] letter_of(input logic [2:0] row, input logic [2:0] col);
    logic [IDX_W-1:0] lin;
    logic [7:0]       l;
    lin = IDX_W'(row) * SIDE + IDX_W'(col);
    if (lin < 5'd9) l = ASCII_A + 8'(lin);
    else            l = ASCII_A + 8'(lin) + 8'd1;
    return l;
  endfunction

endpackage

### sv/fsq_square.sv
// ----------------------------------------------------------------------------
// fsq_square
// One 25-entry key square: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module fsq_square (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [fsq_pkg::IDX_W-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [fsq_pkg::IDX_W-1:0] raddr,
  output logic [7:0]               rdata
);
  import fsq_pkg::*;

  logic [7:0]             mem [SQUARE_SIZE];
  logic [SQUARE_SIZE-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : 8'h00;
    end
  end

endmodule

### sv/fsq_scan.sv
// ----------------------------------------------------------------------------
// fsq_scan
// Walks both key squares in step, one address a cycle, and records the
// lowest index at which each key byte is found.
// ----------------------------------------------------------------------------
module fsq_scan (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [7:0]                key_a,
  input  logic [7:0]                key_b,
  output logic                      re,
  output logic [fsq_pkg::IDX_W-1:0] raddr,
  input  logic [7:0]                rdata_a,
  input  logic [7:0]                rdata_b,
  output logic                      done,
  output fsq_pkg::scan_result_t     result
);
  import fsq_pkg::*;

  logic             busy;
  logic [IDX_W-1:0] issue;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;

  assign re    = busy;
  assign raddr = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      issue     <= '0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      cmp_valid <= busy;
      done      <= cmp_valid && (cmp_idx == LAST_IDX);
      if (start) begin
        busy  <= 1'b1;
        issue <= '0;
      end else if (busy) begin
        if (issue == LAST_IDX) busy <= 1'b0;
        else                   issue <= issue + 5'd1;
      end
    end
  end

  // read data comes back the cycle after its address is issued
  always_ff @(posedge clk) begin
    cmp_idx <= issue;
    if (start) begin
      result.found_a <= 1'b0;
      result.found_b <= 1'b0;
    end else if (cmp_valid) begin
      if (!result.found_a && (rdata_a == key_a)) begin
        result.found_a <= 1'b1;
        result.idx_a   <= cmp_idx;
      end
      if (!result.found_b && (rdata_b == key_b)) begin
        result.found_b <= 1'b1;
        result.idx_b   <= cmp_idx;
      end
    end
  end

endmodule

### sv/four_square_decrypt.sv
// ----------------------------------------------------------------------------
// four_square_decrypt
// Four-square cipher decrypter with two loadable key squares.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries load and text transactions.
//   op 0/1 writes symbol into square one/two at position (above 24 ignored);
//   op 2 is a ciphertext byte, op 3 is dropped.
//   Text bytes pair up: the first is held. The second starts a scan of both
//   squares, one entry per cycle through their read ports; once the scan is
//   done and the buffer is empty, the pair's first result is presented and the
//   second follows once the first is taken. No input is taken during a scan,
//   so the 25-entry scan bounds throughput.
//   A lone final byte (end_of_text on an unpaired byte) passes straight
//   into the result buffer, behind any result still waiting.
//   Output channel (out_valid/out_ready) is a two-entry result buffer, so
//   loads and first bytes are still taken while one result waits; a full
//   buffer holds the input off, and a receiver stall also holds the pair's
//   write-back until the buffer has drained.
//   Reset clears both squares to zero, the held byte and the buffer.
// ----------------------------------------------------------------------------
module four_square_decrypt (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [4:0] position,
  input  logic [7:0] symbol,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] letter,
  output logic       last_of_text,
  output logic       not_in_key
);
  import fsq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       holding;
  logic [7:0] held_byte;
  logic [7:0] second_byte;
  logic       second_eot;

  out_item_t  slot0, slot1, slot0_next, slot1_next;
  logic [1:0] count, count_next;

  logic       accept;
  logic       we_one, we_two;
  logic       pos_ok;
  logic       push1, push2, pop;
  logic       start;
  logic       scan_done;
  logic       re;
  logic [IDX_W-1:0] raddr;
  logic [7:0] rdata_one, rdata_two;
  scan_result_t scan_res;
  out_item_t  lone_item, first_item, second_item;

  assign in_ready = (state == S_IDLE) && (count != 2'd2);
  assign accept   = in_valid && in_ready;
  assign pos_ok   = (position <= LAST_IDX);
  assign we_one   = accept && (op == OP_LOAD_ONE) && pos_ok;
  assign we_two   = accept && (op == OP_LOAD_TWO) && pos_ok;
  assign push1    = accept && (op == OP_TEXT) && !holding && end_of_text;
  assign start    = accept && (op == OP_TEXT) && holding;
  assign push2    = (state == S_EMIT) && (count == 2'd0);
  assign pop      = out_valid && out_ready;

  fsq_square u_square_one (
    .clk   (clk),
    .rst   (rst),
    .we    (we_one),
    .waddr (position),
    .wdata (symbol),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_one)
  );

  fsq_square u_square_two (
    .clk   (clk),
    .rst   (rst),
    .we    (we_two),
    .waddr (position),
    .wdata (symbol),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_two)
  );

  fsq_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .key_a   (held_byte),
    .key_b   (second_byte),
    .re      (re),
    .raddr   (raddr),
    .rdata_a (rdata_one),
    .rdata_b (rdata_two),
    .done    (scan_done),
    .result  (scan_res)
  );

  // second_byte is captured at start and holds the pair's second byte for the
  // whole scan
  always_comb begin
    lone_item = '{letter: symbol, last: 1'b1, err: 1'b0};
    if (scan_res.found_a && scan_res.found_b) begin
      first_item  = '{letter: letter_of(row_of(scan_res.idx_a), col_of(scan_res.idx_b)),
                      last: 1'b0, err: 1'b0};
      second_item = '{letter: letter_of(row_of(scan_res.idx_b), col_of(scan_res.idx_a)),
                      last: second_eot, err: 1'b0};
    end else begin
      first_item  = '{letter: held_byte, last: 1'b0, err: 1'b1};
      second_item = '{letter: second_byte, last: second_eot, err: 1'b1};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_SCAN;
      S_SCAN:  if (scan_done) state_next = S_EMIT;
      S_EMIT:  if (push2) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // two-entry result buffer, head in slot0
  always_comb begin
    slot0_next = slot0;
    slot1_next = slot1;
    count_next = count;
    if (pop) begin
      slot0_next = slot1;
      count_next = count - 2'd1;
    end
    if (push1) begin
      if (count_next == 2'd0) slot0_next = lone_item;
      else                    slot1_next = lone_item;
      count_next = count_next + 2'd1;
    end else if (push2) begin
      slot0_next = first_item;
      slot1_next = second_item;
      count_next = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      holding   <= 1'b0;
      held_byte <= 8'h00;
      count     <= 2'd0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (accept && (op == OP_TEXT)) begin
        if (holding) begin
          holding <= 1'b0;
        end else if (!end_of_text) begin
          holding   <= 1'b1;
          held_byte <= symbol;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
    if (start) begin
      second_byte <= symbol;
      second_eot  <= end_of_text;
    end
  end

  assign out_valid    = (count != 2'd0);
  assign letter       = slot0.letter;
  assign last_of_text = slot0.last;
  assign not_in_key   = slot0.err;

endmodule
